FILE: rtl/cbez_pkg.sv
// Shared types and register index codes for the cubic Bezier point evaluator.
package cbez_pkg;

    // Configuration register index
    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_POINT_ZERO  = 2'd0;
    localparam t_reg_idx REG_POINT_ONE   = 2'd1;
    localparam t_reg_idx REG_POINT_TWO   = 2'd2;
    localparam t_reg_idx REG_POINT_THREE = 2'd3;

    localparam int NUM_POINTS = 4;
    localparam int NUM_AXES   = 3;

endpackage

FILE: rtl/cubic_bezier_point_evaluator_core.sv
// Throughput: one point per cycle while the output is not stalled; three de Casteljau
// rounds, each a multiply stage (difference times t) followed by a shift-and-add stage,
// after a t clamp stage; each point word leaves from the output register.
// A stalled output holds every stage; empty stages are filled while stalled.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears all control points.
// Control points may only be rewritten while the pipeline is empty.
module cubic_bezier_point_evaluator_core #(
    parameter int COORD_WIDTH = 20,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  cbez_pkg::t_reg_idx             i_cfg_index,
    input  logic [3*COORD_WIDTH-1:0]       i_cfg_data,
    // parameter input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [T_FRAC_BITS:0]           i_t_value,
    // point output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [COORD_WIDTH-1:0]  o_x_out,
    output logic signed [COORD_WIDTH-1:0]  o_y_out,
    output logic signed [COORD_WIDTH-1:0]  o_z_out
);
    import cbez_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int TW   = T_FRAC_BITS + 1;
    localparam int PW   = COORD_WIDTH + T_FRAC_BITS + 2;
    localparam int NSTG = 7;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic [TW-1:0]        t_param;

    localparam t_param T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    // t * (b - a), full precision
    function automatic t_prod lerp_mul(t_param t, t_coord a, t_coord b);
        logic signed [CW:0] d;
        logic signed [TW:0] ts;
        d  = (CW+1)'(b) - (CW+1)'(a);
        ts = $signed({1'b0, t});
        return PW'(d) * PW'(ts);
    endfunction

    // a + floor(p / 2^T_FRAC_BITS); stays between the two lerp operands
    function automatic t_coord lerp_add(t_coord a, t_prod p);
        t_prod s;
        s = PW'(a) + (p >>> T_FRAC_BITS);
        return s[CW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Control point registers
    // ------------------------------------------------------------------
    logic [3*CW-1:0] r_pt [NUM_POINTS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_POINTS; k++) begin
                r_pt[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POINT_ZERO:  r_pt[0] <= i_cfg_data;
                REG_POINT_ONE:   r_pt[1] <= i_cfg_data;
                REG_POINT_TWO:   r_pt[2] <= i_cfg_data;
                REG_POINT_THREE: r_pt[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when the next loads
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    t_param r_t0, r_t1, r_t2, r_t3, r_t4;
    t_coord r_m1_a [NUM_AXES][3];
    t_prod  r_m1_p [NUM_AXES][3];
    t_coord r_q1   [NUM_AXES][3];
    t_coord r_m2_a [NUM_AXES][2];
    t_prod  r_m2_p [NUM_AXES][2];
    t_coord r_q2   [NUM_AXES][2];
    t_coord r_m3_a [NUM_AXES];
    t_prod  r_m3_p [NUM_AXES];
    t_coord r_q3   [NUM_AXES];

    t_param n_t0;
    t_coord n_m1_a [NUM_AXES][3];
    t_prod  n_m1_p [NUM_AXES][3];
    t_coord n_q1   [NUM_AXES][3];
    t_coord n_m2_a [NUM_AXES][2];
    t_prod  n_m2_p [NUM_AXES][2];
    t_coord n_q2   [NUM_AXES][2];
    t_coord n_m3_a [NUM_AXES];
    t_prod  n_m3_p [NUM_AXES];
    t_coord n_q3   [NUM_AXES];

    // clamp t to one
    assign n_t0 = (i_t_value > T_ONE) ? T_ONE : i_t_value;

    // round logic per axis
    always_comb begin
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            // round one: products against control points
            for (int j = 0; j < 3; j++) begin
                n_m1_a[ax][j] = r_pt[j][ax*CW +: CW];
                n_m1_p[ax][j] = lerp_mul(r_t0, r_pt[j][ax*CW +: CW],
                                         r_pt[j+1][ax*CW +: CW]);
                n_q1[ax][j]   = lerp_add(r_m1_a[ax][j], r_m1_p[ax][j]);
            end
            // round two
            for (int j = 0; j < 2; j++) begin
                n_m2_a[ax][j] = r_q1[ax][j];
                n_m2_p[ax][j] = lerp_mul(r_t2, r_q1[ax][j], r_q1[ax][j+1]);
                n_q2[ax][j]   = lerp_add(r_m2_a[ax][j], r_m2_p[ax][j]);
            end
            // round three
            n_m3_a[ax] = r_q2[ax][0];
            n_m3_p[ax] = lerp_mul(r_t4, r_q2[ax][0], r_q2[ax][1]);
            n_q3[ax]   = lerp_add(r_m3_a[ax], r_m3_p[ax]);
        end
    end

    // stage registers, advanced by their enables
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_t0 <= n_t0;
        end
        if (w_en[1]) begin
            r_t1   <= r_t0;
            r_m1_a <= n_m1_a;
            r_m1_p <= n_m1_p;
        end
        if (w_en[2]) begin
            r_t2 <= r_t1;
            r_q1 <= n_q1;
        end
        if (w_en[3]) begin
            r_t3   <= r_t2;
            r_m2_a <= n_m2_a;
            r_m2_p <= n_m2_p;
        end
        if (w_en[4]) begin
            r_t4 <= r_t3;
            r_q2 <= n_q2;
        end
        if (w_en[5]) begin
            r_m3_a <= n_m3_a;
            r_m3_p <= n_m3_p;
        end
        if (w_en[6]) begin
            r_q3 <= n_q3;
        end
    end

    assign o_x_out = r_q3[0];
    assign o_y_out = r_q3[1];
    assign o_z_out = r_q3[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_t_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_t0 <= T_ONE))
        else $error("clamped t exceeds one");

    a_busy_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    a_t_travels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en[3] && r_vld[2]) |=> (r_t3 == $past(r_t2)))
        else $error("t lost between rounds");

endmodule
